/* rtl/assert_macros.svh */
// Assertion helpers used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/espsc_pkg.sv */
// ----------------------------------------------------------------------------
// espsc_pkg
// Shared types and constants of the escape histogram spread scorer.
// ----------------------------------------------------------------------------
package espsc_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned SCORE_BITS = 24;
  localparam logic [SCORE_BITS-1:0] SCORE_MAX = 24'hFFFFFF;
  localparam logic [7:0] MV_CAP = 8'd255;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAIN,
    ST_BG_SWEEP,
    ST_BG_ZERO,
    ST_REM,
    ST_WALK_SWEEP,
    ST_WALK_DECIDE,
    ST_QUOT_DIV,
    ST_LHS,
    ST_VCALC,
    ST_MUL_START,
    ST_MUL,
    ST_SCORE_DIV,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    OP_QUOT,
    OP_MUL,
    OP_SCORE
  } arith_op_e;

  typedef struct packed {
    logic      clr_start;
    logic      fin_init;
    logic      sweep_start;
    logic      sweep_first;
    logic      zero_best;
    logic      take_skip;
    logic      arith_start;
    arith_op_e arith_op;
    logic      load_stop;
    logic      walk_take;
    logic      load_q16;
    logic      calc_lhs;
    logic      calc_v;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic sweep_done;
    logic walk_stop;
    logic arith_done;
    logic out_full;
  } ctrl_status_t;

endpackage

/* rtl/escape_histogram_spread_score_top.sv */
// ----------------------------------------------------------------------------
// escape_histogram_spread_score_top
// Escape-bin histogram with a background-aware spread score on finish.
// ----------------------------------------------------------------------------
// Input beats carry an escape bin in s_axis_tdata and a command in s_axis_tuser:
// a pixel beat adds one to that bin and to the pixel total, a finish beat
// computes the score. Only a finish beat yields an output beat, with the 8.16
// score and the capped max value in m_axis_tdata.
// Pixel beats are taken one per cycle while the controller is idle; the
// histogram read-modify-write is a two-stage pipeline with forwarding
// between consecutive beats to one bin. A finish beat holds s_axis_tready
// low while the controller runs full sweeps of the histogram memory, each
// over all NB = MAX_ITERS+1 bins: two for the background bins and one per
// walked bin plus one more. Then come a serial divide, a multiply and a
// second divide in the shared unit of width DW = clog2(NB) + 17 + COUNT_BITS,
// and a clearing pass over all NB bins.
// After reset the same clearing pass runs over all NB bins before the first beat
// is accepted. The output register frees the input side: pixel beats flow while
// a result waits; a later finish waits only if the previous result is unread.
// ----------------------------------------------------------------------------
module escape_histogram_spread_score_top #(
  parameter int MAX_ITERS = 255,
  parameter int COUNT_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] escape_bin
  input  logic [0:0]  s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [23:0] score, [31:24] max_value
);

  localparam int AW = $clog2(MAX_ITERS + 1);

  espsc_pkg::ctrl_cmd_t    cmd;
  espsc_pkg::ctrl_status_t st;
  logic                    in_acc, pix_start, bin_ok;
  logic [espsc_pkg::SCORE_BITS-1:0] score;
  logic [7:0]              max_value;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign bin_ok    = 32'(s_axis_tdata) <= 32'(MAX_ITERS);
  assign pix_start = in_acc && (s_axis_tuser[0] == espsc_pkg::CMD_PIXEL) && bin_ok;

  espsc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_acc_i  (in_acc),
    .finish_i  (s_axis_tuser[0] == espsc_pkg::CMD_FINISH),
    .st_i      (st),
    .cmd_o     (cmd),
    .in_ready_o(s_axis_tready)
  );

  espsc_dp #(.MAX_ITERS(MAX_ITERS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .st_o       (st),
    .pix_start_i(pix_start),
    .pix_addr_i (AW'(s_axis_tdata)),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .score_o    (score),
    .max_value_o(max_value)
  );

  assign m_axis_tdata = {max_value, score};

endmodule

/* rtl/espsc_arith.sv */
// ----------------------------------------------------------------------------
// espsc_arith
// Shared bit-serial unit: shift-add multiply or restoring divide, one bit a cycle.
// ----------------------------------------------------------------------------
module espsc_arith #(
  parameter int DW = 49,
  parameter int CB = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          mul_i,
  input  logic [DW-1:0] a_i,
  input  logic [CB-1:0] b_i,
  output logic          done_o,
  output logic [DW-1:0] res_o
);

  localparam int CW = $clog2(DW);

  logic          busy_q, done_q, mul_q, dz_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] acc_q, mc_q;
  logic [CB-1:0] mp_q, rem_q;
  logic [CB:0]   trial;
  logic          fits;

  assign trial = {rem_q, acc_q[DW-1]};
  assign fits  = trial >= {1'b0, mp_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= mul_i ? CW'(CB - 1) : CW'(DW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mul_q <= mul_i;
      dz_q  <= (b_i == '0);
      mp_q  <= b_i;
      rem_q <= '0;
      mc_q  <= a_i;
      acc_q <= mul_i ? '0 : a_i;
    end else if (busy_q) begin
      if (mul_q) begin
        if (mp_q[0]) begin
          acc_q <= acc_q + mc_q;
        end
        mc_q <= {mc_q[DW-2:0], 1'b0};
        mp_q <= {1'b0, mp_q[CB-1:1]};
      end else begin
        rem_q <= fits ? CB'(trial - {1'b0, mp_q}) : trial[CB-1:0];
        acc_q <= {acc_q[DW-2:0], fits};
      end
    end
  end

  // A zero divisor yields a zero quotient.
  assign res_o  = (!mul_q && dz_q) ? '0 : acc_q;
  assign done_o = done_q;

endmodule

/* rtl/espsc_dp.sv */
// ----------------------------------------------------------------------------
// espsc_dp
// Datapath: histogram memory, pixel update, sweeps, finish arithmetic, output.
// ----------------------------------------------------------------------------
module espsc_dp #(
  parameter int MAX_ITERS = 255,
  parameter int COUNT_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  espsc_pkg::ctrl_cmd_t          cmd_i,
  output espsc_pkg::ctrl_status_t       st_o,
  input  logic                          pix_start_i,
  input  logic [$clog2(MAX_ITERS+1)-1:0] pix_addr_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [espsc_pkg::SCORE_BITS-1:0] score_o,
  output logic [7:0]                    max_value_o
);

  localparam int NB = MAX_ITERS + 1;
  localparam int AW = $clog2(NB);
  localparam int CB = COUNT_BITS;
  localparam int FB = espsc_pkg::FRAC_BITS;
  localparam int VB = AW + FB + 1;
  localparam int RB = VB + 1;
  localparam int DW = VB + CB;
  localparam int LW = AW + CB + 5;
  localparam int MW = AW + 10;
  localparam int QB = FB + 1;
  // Division by three as a multiply by the reciprocal of three scaled by 2^SS, rounded up.
  localparam int SS = CB + 3;
  localparam int PW = CB + 1 + SS;
  localparam logic [SS-1:0] RCP = SS'(((64'd1 << SS) + 64'd2) / 64'd3);
  localparam logic [CB-1:0] CNT_MAX = {CB{1'b1}};
  localparam logic [AW-1:0] LAST = AW'(NB - 1);
  localparam logic [RB-1:0] V_HI = RB'((MAX_ITERS + 5) * (1 << FB));
  localparam logic [RB-1:0] V_MID = RB'((MAX_ITERS - 10) * (1 << FB));

  logic [CB-1:0] mem_q [NB];
  logic [CB-1:0] rdata_q;

  logic          pend_q, lw_vld_q, sw_run_q, clr_run_q, rd_vld_q, first_q, out_valid_q;
  logic [AW-1:0] pend_addr_q, lw_addr_q, cnt_q, rd_idx_q, best_idx_q, top_q;
  logic [CB-1:0] lw_data_q, total_q, best_q, stop_q, dpix_q;
  logic [CB:0]   skip_q;
  logic [AW:0]   bc_q;
  logic [QB-1:0] q16_q;
  logic          gt10_q, gt5_q;
  logic [RB-1:0] ret_q;
  logic [VB-1:0] v_q;
  logic [espsc_pkg::SCORE_BITS-1:0] score_q;
  logic [7:0]    mv_q;

  logic [CB-1:0] cur, inc, rem, den, numr, num, wdata;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [LW-1:0] lhs;
  logic [RB-1:0] vsel;
  logic [DW-1:0] ar_a, ar_res, ssel;
  logic [CB-1:0] ar_b;
  logic          ar_done;
  logic [MW-1:0] mvw;
  logic [PW-1:0] stop_prod;

  // Forward the previous write when back-to-back pixels hit the same bin.
  assign cur = (lw_vld_q && lw_addr_q == pend_addr_q) ? lw_data_q : rdata_q;
  assign inc = (cur == CNT_MAX) ? cur : cur + CB'(1);

  assign raddr = sw_run_q ? cnt_q : pix_addr_i;

  always_comb begin
    we    = 1'b0;
    waddr = pend_addr_q;
    wdata = inc;
    if (clr_run_q) begin
      we    = 1'b1;
      waddr = cnt_q;
      wdata = '0;
    end else if (cmd_i.zero_best) begin
      we    = 1'b1;
      waddr = best_idx_q;
      wdata = '0;
    end else if (pend_q) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  assign rem  = ({1'b0, total_q} > skip_q) ? CB'({1'b0, total_q} - skip_q) : '0;
  assign den  = (best_q == '0) ? CB'(1) : best_q;
  assign numr = (best_q != '0 && stop_q > dpix_q) ? stop_q - dpix_q : '0;
  assign num  = (numr > den) ? den : numr;
  assign lhs  = LW'(bc_q) * LW'(den) + LW'(num);

  assign stop_prod = PW'({rem, 1'b0}) * PW'(RCP);

  always_comb begin
    if (gt10_q) begin
      vsel = (ret_q > V_HI) ? '0 : V_HI - ret_q;
    end else if (gt5_q) begin
      vsel = V_MID + ret_q;
    end else begin
      vsel = ret_q;
    end
  end

  always_comb begin
    case (cmd_i.arith_op)
      espsc_pkg::OP_QUOT: begin
        ar_a = DW'({num, {FB{1'b0}}});
        ar_b = den;
      end
      espsc_pkg::OP_MUL: begin
        ar_a = DW'(v_q);
        ar_b = rem;
      end
      default: begin
        ar_a = ar_res;
        ar_b = total_q;
      end
    endcase
  end

  espsc_arith #(.DW(DW), .CB(CB)) u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.arith_start),
    .mul_i  (cmd_i.arith_op == espsc_pkg::OP_MUL),
    .a_i    (ar_a),
    .b_i    (ar_b),
    .done_o (ar_done),
    .res_o  (ar_res)
  );

  always_comb begin
    if (total_q == '0) begin
      ssel = DW'(v_q);
    end else if (skip_q >= {1'b0, total_q}) begin
      ssel = '0;
    end else begin
      ssel = ar_res;
    end
  end

  assign mvw = (MW'(top_q) * MW'(3)) >> 1;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      lw_vld_q    <= 1'b0;
      sw_run_q    <= 1'b0;
      clr_run_q   <= 1'b1;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      pend_q   <= pix_start_i;
      lw_vld_q <= pend_q;
      rd_vld_q <= sw_run_q;
      if (pend_q && total_q != CNT_MAX) begin
        total_q <= total_q + CB'(1);
      end
      if (cmd_i.clr_start) begin
        clr_run_q <= 1'b1;
        cnt_q     <= '0;
        total_q   <= '0;
      end else if (cmd_i.sweep_start) begin
        sw_run_q <= 1'b1;
        cnt_q    <= '0;
        first_q  <= cmd_i.sweep_first;
      end else if (sw_run_q || clr_run_q) begin
        cnt_q <= cnt_q + AW'(1);
        if (cnt_q == LAST) begin
          sw_run_q  <= 1'b0;
          clr_run_q <= 1'b0;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    lw_addr_q <= pend_addr_q;
    lw_data_q <= inc;
    rd_idx_q  <= cnt_q;
    if (pix_start_i) begin
      pend_addr_q <= pix_addr_i;
    end
    if (cmd_i.sweep_start) begin
      best_q     <= '0;
      best_idx_q <= '0;
    end else if (rd_vld_q && rdata_q > best_q) begin
      best_q     <= rdata_q;
      best_idx_q <= rd_idx_q;
    end
    if (cmd_i.fin_init) begin
      skip_q <= '0;
      dpix_q <= '0;
      bc_q   <= '0;
      top_q  <= '0;
    end else begin
      if (rd_vld_q && first_q && rdata_q != '0) begin
        top_q <= rd_idx_q;
      end
      if (cmd_i.take_skip) begin
        skip_q <= skip_q + {1'b0, best_q};
      end
      if (cmd_i.walk_take) begin
        dpix_q <= dpix_q + best_q;
        bc_q   <= bc_q + (AW+1)'(1);
      end
    end
    if (cmd_i.load_stop) begin
      stop_q <= CB'(stop_prod[PW-1:SS]);
    end
    if (cmd_i.load_q16) begin
      q16_q <= QB'(ar_res);
    end
    if (cmd_i.calc_lhs) begin
      gt10_q <= lhs > LW'(den) * LW'(10);
      gt5_q  <= lhs > LW'(den) * LW'(5);
      ret_q  <= RB'({bc_q, {FB{1'b0}}}) + RB'(q16_q);
    end
    if (cmd_i.calc_v) begin
      v_q <= VB'(vsel);
    end
    if (cmd_i.out_load) begin
      score_q <= (ssel > DW'(espsc_pkg::SCORE_MAX)) ? espsc_pkg::SCORE_MAX
                                                     : ssel[espsc_pkg::SCORE_BITS-1:0];
      mv_q    <= (mvw > MW'(espsc_pkg::MV_CAP)) ? espsc_pkg::MV_CAP : mvw[7:0];
    end
  end

  assign st_o.clr_done   = clr_run_q && cnt_q == LAST;
  assign st_o.sweep_done = rd_vld_q && rd_idx_q == LAST;
  assign st_o.walk_stop  = (best_q == '0) ||
                           (({1'b0, dpix_q} + {1'b0, best_q}) >= {1'b0, stop_q});
  assign st_o.arith_done = ar_done;
  assign st_o.out_full   = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign score_o     = score_q;
  assign max_value_o = mv_q;

endmodule

/* rtl/espsc_ctrl.sv */
// ----------------------------------------------------------------------------
// espsc_ctrl
// Sequencer for clearing, pixel intake and the multi-pass finish computation.
// ----------------------------------------------------------------------------
module espsc_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_acc_i,
  input  logic                    finish_i,
  input  espsc_pkg::ctrl_status_t st_i,
  output espsc_pkg::ctrl_cmd_t    cmd_o,
  output logic                    in_ready_o
);

  espsc_pkg::ctrl_state_e state_q, state_d;
  logic second_q, second_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= espsc_pkg::ST_CLEAR;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    second_d   = second_q;
    in_ready_o = 1'b0;
    case (state_q)
      espsc_pkg::ST_CLEAR: begin
        if (st_i.clr_done) state_d = espsc_pkg::ST_IDLE;
      end
      espsc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_acc_i && finish_i) begin
          cmd_o.fin_init = 1'b1;
          state_d        = espsc_pkg::ST_DRAIN;
        end
      end
      espsc_pkg::ST_DRAIN: begin
        cmd_o.sweep_start = 1'b1;
        cmd_o.sweep_first = 1'b1;
        second_d          = 1'b0;
        state_d           = espsc_pkg::ST_BG_SWEEP;
      end
      espsc_pkg::ST_BG_SWEEP: begin
        if (st_i.sweep_done) state_d = espsc_pkg::ST_BG_ZERO;
      end
      espsc_pkg::ST_BG_ZERO: begin
        cmd_o.zero_best = 1'b1;
        cmd_o.take_skip = 1'b1;
        if (!second_q) begin
          second_d          = 1'b1;
          cmd_o.sweep_start = 1'b1;
          state_d           = espsc_pkg::ST_BG_SWEEP;
        end else begin
          state_d = espsc_pkg::ST_REM;
        end
      end
      espsc_pkg::ST_REM: begin
        cmd_o.load_stop   = 1'b1;
        cmd_o.sweep_start = 1'b1;
        state_d           = espsc_pkg::ST_WALK_SWEEP;
      end
      espsc_pkg::ST_WALK_SWEEP: begin
        if (st_i.sweep_done) state_d = espsc_pkg::ST_WALK_DECIDE;
      end
      espsc_pkg::ST_WALK_DECIDE: begin
        if (st_i.walk_stop) begin
          cmd_o.arith_start = 1'b1;
          cmd_o.arith_op    = espsc_pkg::OP_QUOT;
          state_d           = espsc_pkg::ST_QUOT_DIV;
        end else begin
          cmd_o.walk_take   = 1'b1;
          cmd_o.zero_best   = 1'b1;
          cmd_o.sweep_start = 1'b1;
          state_d           = espsc_pkg::ST_WALK_SWEEP;
        end
      end
      espsc_pkg::ST_QUOT_DIV: begin
        cmd_o.arith_op = espsc_pkg::OP_QUOT;
        if (st_i.arith_done) begin
          cmd_o.load_q16 = 1'b1;
          state_d        = espsc_pkg::ST_LHS;
        end
      end
      espsc_pkg::ST_LHS: begin
        cmd_o.calc_lhs = 1'b1;
        state_d        = espsc_pkg::ST_VCALC;
      end
      espsc_pkg::ST_VCALC: begin
        cmd_o.calc_v = 1'b1;
        state_d      = espsc_pkg::ST_MUL_START;
      end
      espsc_pkg::ST_MUL_START: begin
        cmd_o.arith_start = 1'b1;
        cmd_o.arith_op    = espsc_pkg::OP_MUL;
        state_d           = espsc_pkg::ST_MUL;
      end
      espsc_pkg::ST_MUL: begin
        cmd_o.arith_op = espsc_pkg::OP_SCORE;
        if (st_i.arith_done) begin
          cmd_o.arith_start = 1'b1;
          state_d           = espsc_pkg::ST_SCORE_DIV;
        end
      end
      espsc_pkg::ST_SCORE_DIV: begin
        cmd_o.arith_op = espsc_pkg::OP_SCORE;
        if (st_i.arith_done) state_d = espsc_pkg::ST_OUT;
      end
      espsc_pkg::ST_OUT: begin
        cmd_o.arith_op = espsc_pkg::OP_SCORE;
        if (!st_i.out_full) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.clr_start = 1'b1;
          state_d         = espsc_pkg::ST_CLEAR;
        end
      end
      default: begin
        state_d = espsc_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

/* rtl/espsc_checker.sv */
// ----------------------------------------------------------------------------
// espsc_checker
// Port-level checks of the spread scorer, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module espsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled output beat changed")
  `ASSERT_ALWAYS(a_no_ready_in_reset, clk_i, !rst_ni |-> !s_axis_tready, "ready high during reset")
  `ASSERT_CLK(a_finish_busy, clk_i, rst_ni, in_acc && s_axis_tuser[0] |=> !s_axis_tready, "input ready right after a finish beat")
  `ASSERT_CLK(a_pixel_silent, clk_i, rst_ni, in_acc && !s_axis_tuser[0] && !m_axis_tvalid |=> !m_axis_tvalid, "pixel beat produced a result")

endmodule

bind escape_histogram_spread_score_top espsc_checker u_espsc_checker (.*);

/* test/spread_score_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spread_score_checker
// Watches both streams of the spread scorer, keeps its own histogram, predicts
// the score and max value of every finish beat and compares output beats.
// ----------------------------------------------------------------------------
module spread_score_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  output int          errors_o,
  output int          pending_o
);

  localparam int unsigned NBINS = 256;
  localparam int unsigned CNT_MAX = 24'hFFFFFF;
  localparam int unsigned MAX_IT = 255;

  int unsigned hist [NBINS];
  int unsigned pix_total;
  logic [31:0] expected_results [$];

  assign pending_o = expected_results.size();

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors_o++;
  endtask

  function automatic int unsigned peak_bin(input int unsigned h [NBINS]);
    int unsigned p;
    p = 0;
    for (int n = 1; n < NBINS; n++)
      if (h[n] > h[p]) p = n;
    return p;
  endfunction

  // Background removal, two-thirds walk, fold and scaling on one finish beat.
  function automatic logic [31:0] spread_result(input int unsigned h [NBINS],
                                                input int unsigned tot);
    longint unsigned mv, skip, rem, stop, covered, bc, c, num, den, lhs, ret, sc;
    longint signed   v;
    int unsigned     p;
    mv = 0;
    for (int n = NBINS - 1; n >= 0; n--)
      if (h[n] > 0) begin
        mv = n;
        break;
      end
    mv = mv * 3 / 2;
    if (mv > 255) mv = 255;
    p = peak_bin(h);
    skip = h[p];
    h[p] = 0;
    p = peak_bin(h);
    skip += h[p];
    h[p] = 0;
    rem = (tot > skip) ? tot - skip : 0;
    stop = rem * 2 / 3;
    covered = 0;
    bc = 0;
    c = 0;
    for (int it = 0; it <= NBINS; it++) begin
      p = peak_bin(h);
      c = h[p];
      if (c == 0 || covered + c >= stop) break;
      covered += c;
      bc++;
      h[p] = 0;
    end
    den = (c != 0) ? c : 1;
    num = (c != 0 && stop > covered) ? stop - covered : 0;
    if (num > den) num = den;
    lhs = bc * den + num;
    ret = bc * 65536 + (num * 65536) / den;
    if (lhs > 10 * den) begin
      v = longint'((MAX_IT + 5) * 65536) - longint'(ret);
      if (v < 0) v = 0;
    end else if (lhs > 5 * den) begin
      v = longint'((MAX_IT - 10) * 65536 + ret);
    end else begin
      v = longint'(ret);
    end
    if (tot == 0) sc = longint'(v);
    else if (skip >= tot) sc = 0;
    else sc = longint'(v) * (tot - skip) / tot;
    if (sc > 24'hFFFFFF) sc = 24'hFFFFFF;
    return {mv[7:0], sc[23:0]};
  endfunction

  initial errors_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (hist[n]) hist[n] = 0;
      pix_total = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == espsc_pkg::CMD_PIXEL) begin
          if (hist[s_axis_tdata] < CNT_MAX) hist[s_axis_tdata]++;
          if (pix_total < CNT_MAX) pix_total++;
        end else begin
          expected_results.push_back(spread_result(hist, pix_total));
          foreach (hist[n]) hist[n] = 0;
          pix_total = 0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata, '0);
        end else begin
          logic [31:0] want;
          want = expected_results.pop_front();
          if (m_axis_tdata[23:0] != want[23:0])
            report_mismatch("score", 32'(m_axis_tdata[23:0]), 32'(want[23:0]));
          if (m_axis_tdata[31:24] != want[31:24])
            report_mismatch("max_value", 32'(m_axis_tdata[31:24]), 32'(want[31:24]));
        end
      end
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixel and finish beats into the spread scorer with random gaps on
// both sides; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  int          errors;
  int          pending;
  int          idle_cycles = 0;
  int          sent = 0;
  bit          no_gaps = 0;

  always #1 clk_i = ~clk_i;

  escape_histogram_spread_score_top dut (.*);

  spread_score_checker checker_i (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .errors_o(errors), .pending_o(pending)
  );

  task automatic send_beat(input logic cmd, input logic [7:0] bin);
    if (!no_gaps) repeat ($urandom_range(0, 13)) @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = cmd;
    s_axis_tdata = bin;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    sent++;
  endtask

  // One frame of pixels drawn mostly from a small palette, so that the walk
  // stays short and ties between bins are common.
  task automatic send_frame(input int npix);
    logic [7:0] palette [8];
    int         ncol;
    bit         wide;
    ncol = $urandom_range(1, 8);
    wide = ($urandom_range(0, 9) == 0);
    foreach (palette[k]) palette[k] = 8'($urandom);
    for (int k = 0; k < npix; k++)
      send_beat(espsc_pkg::CMD_PIXEL,
                wide ? 8'($urandom) : palette[$urandom_range(0, ncol - 1)]);
    if ($urandom_range(0, 7) == 0) wait (pending == 0);
    send_beat(espsc_pkg::CMD_FINISH, 8'($urandom));
  endtask

  // Result side: a random stall before each beat.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      m_axis_tready = 1'b0;
      if (!no_gaps) repeat ($urandom_range(0, 13)) @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[escape_histogram_spread_score_top] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    // Extreme bins, an empty finish and a histogram with only background.
    send_beat(espsc_pkg::CMD_PIXEL, 8'd0);
    send_beat(espsc_pkg::CMD_PIXEL, 8'd255);
    send_beat(espsc_pkg::CMD_FINISH, 8'hFF);
    send_beat(espsc_pkg::CMD_FINISH, 8'h00);
    repeat (3) send_beat(espsc_pkg::CMD_PIXEL, 8'd7);
    send_beat(espsc_pkg::CMD_PIXEL, 8'd200);
    send_beat(espsc_pkg::CMD_FINISH, 8'h55);
    // Equal counts everywhere exercise lowest-index tie breaking.
    for (int k = 0; k < 6; k++) send_beat(espsc_pkg::CMD_PIXEL, 8'(k * 40 + 3));
    send_beat(espsc_pkg::CMD_FINISH, 8'hAA);
    wait (pending == 0);
    for (int k = 0; k < 8; k++) send_beat(espsc_pkg::CMD_PIXEL, 8'(1 << k));
    send_beat(espsc_pkg::CMD_FINISH, 8'h01);
    while (sent < 1800) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      send_frame($urandom_range(0, 60));
    end
    no_gaps = 0;
    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("[escape_histogram_spread_score_top] OK");
    end else begin
      $display("[escape_histogram_spread_score_top] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/espsc_pkg.sv
rtl/espsc_arith.sv
rtl/espsc_dp.sv
rtl/espsc_ctrl.sv
rtl/escape_histogram_spread_score_top.sv
rtl/espsc_checker.sv
test/spread_score_checker.sv
test/testbench.sv
